>>> hw/rtl/multi_cpu_priority_scheduler_macros.svh
// assertion macros for the multi-cpu priority scheduler
`ifndef MULTI_CPU_PRIORITY_SCHEDULER_MACROS_SVH
`define MULTI_CPU_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MCPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mcps_pkg.sv
// shared types and constants of the multi-cpu priority scheduler
`default_nettype none

package mcps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QCELLS      = QUEUE_DEPTH + 1;
  localparam int CNT_W       = $clog2(QCELLS + 1);
  localparam int MAX_CPUS    = 8;
  localparam int CPU_W       = 3;
  localparam int CPUN_W      = $clog2(MAX_CPUS + 1);
  localparam int PRIO_W      = 16;
  localparam int PROC_W      = 8;
  localparam int REQ_W       = 3;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int CCNT_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_WAKE    = 3'd0,
    REQ_PREEMPT = 3'd1,
    REQ_YIELD   = 3'd2,
    REQ_TERM    = 3'd3,
    REQ_POLL    = 3'd4
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_PREEMPT  = 2'd1,
    KIND_FULL     = 2'd2
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_SJF  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_MODE = 2'd0,
    CFG_NCPU       = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DISP = 4'b1000
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/multi_cpu_priority_scheduler.sv
// multi-cpu priority scheduler: sorted ready queue, cpu table, shared worst-priority compare
// sequence: an event word is taken in idle and runs in the exec state, and a dispatch adds a disp state;
// a wake in static priority mode then scans the cpu table through one comparator, one cpu
// per cycle while the result register is free, stopping early at an idle cpu; the result word is registered after that
// a new event word is taken only once the last one is through and the block is back in idle
// reset: synchronous, empties the queue, marks every cpu idle, clears the arrival counter, sets fifo mode and one cpu
`default_nettype none
`include "multi_cpu_priority_scheduler_macros.svh"

module multi_cpu_priority_scheduler (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               evt_valid,
  output logic                                    evt_ready,
  input  wire logic [mcps_pkg::REQ_W-1:0]         req_type,
  input  wire logic [mcps_pkg::CPU_W-1:0]         cpu_id,
  input  wire logic [mcps_pkg::PROC_W-1:0]        proc_id,
  input  wire logic                               is_new,
  input  wire logic [mcps_pkg::PRIO_W-1:0]        priority_req,
  input  wire logic [mcps_pkg::PRIO_W-1:0]        job_left,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output logic [mcps_pkg::KIND_W-1:0]             out_kind,
  output logic [mcps_pkg::CPU_W-1:0]              out_cpu,
  output logic [mcps_pkg::PROC_W-1:0]             out_proc,
  output logic                                    out_idle,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mcps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mcps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mcps_pkg::state_t state, state_next;

  // config
  logic [mcps_pkg::MODE_W-1:0] sched_mode;
  logic [mcps_pkg::CCNT_W-1:0] ncpu_cfg;
  logic [mcps_pkg::CPUN_W-1:0] ncpu;

  // latched event word
  mcps_pkg::req_t              req_r;
  logic [mcps_pkg::CPU_W-1:0]  cpu_r;
  logic [mcps_pkg::PROC_W-1:0] proc_r;
  logic                        new_r;
  logic [mcps_pkg::PRIO_W-1:0] preq_r;
  logic [mcps_pkg::PRIO_W-1:0] trem_r;

  // ready queue cells
  logic [mcps_pkg::PROC_W-1:0] qproc [mcps_pkg::QCELLS];
  logic [mcps_pkg::PRIO_W-1:0] qprio [mcps_pkg::QCELLS];
  logic [mcps_pkg::CNT_W-1:0]  qcount, qcount_next;
  logic                        q_ins, q_pop;
  logic [mcps_pkg::PROC_W-1:0] ins_proc;
  logic [mcps_pkg::PRIO_W-1:0] ins_prio;
  logic [mcps_pkg::QCELLS-1:0] le;

  // cpu table
  logic [mcps_pkg::PROC_W-1:0]   run_proc [mcps_pkg::MAX_CPUS];
  logic [mcps_pkg::PRIO_W-1:0]   run_prio [mcps_pkg::MAX_CPUS];
  logic [mcps_pkg::MAX_CPUS-1:0] run_valid;
  logic [mcps_pkg::CPU_W-1:0]    tbl_idx;
  logic [mcps_pkg::PROC_W-1:0]   rd_proc;
  logic [mcps_pkg::PRIO_W-1:0]   rd_prio;
  logic                          rd_valid;
  logic                          tbl_load, tbl_clear;

  // scan unit
  logic [mcps_pkg::CPU_W-1:0]  scan, scan_next;
  logic [mcps_pkg::CPU_W-1:0]  worst, worst_next;
  logic [mcps_pkg::PRIO_W-1:0] worst_prio, worst_prio_next;
  logic [mcps_pkg::PRIO_W-1:0] wake_prio, wake_prio_next;
  logic                        take_worst, scan_last;

  logic [mcps_pkg::PRIO_W-1:0] arrival_counter, arrival_next;

  // result register
  logic                        out_free, emit;
  logic [mcps_pkg::KIND_W-1:0] emit_kind;
  logic [mcps_pkg::CPU_W-1:0]  emit_cpu;
  logic [mcps_pkg::PROC_W-1:0] emit_proc;
  logic                        emit_idle;
  logic [mcps_pkg::PRIO_W-1:0] new_prio;
  logic                        cpu_bad;

  assign evt_ready = (state == mcps_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    if (ncpu_cfg == '0) begin
      ncpu = mcps_pkg::CPUN_W'(1);
    end else if (ncpu_cfg > mcps_pkg::CCNT_W'(mcps_pkg::MAX_CPUS)) begin
      ncpu = mcps_pkg::CPUN_W'(mcps_pkg::MAX_CPUS);
    end else begin
      ncpu = mcps_pkg::CPUN_W'(ncpu_cfg);
    end
  end

  assign tbl_idx  = (state == mcps_pkg::S_SCAN) ? scan : cpu_r;
  assign rd_proc  = run_proc[tbl_idx];
  assign rd_prio  = run_prio[tbl_idx];
  assign rd_valid = run_valid[tbl_idx];
  assign cpu_bad  = mcps_pkg::CPUN_W'(cpu_r) >= ncpu;

  always_comb begin
    if (new_r && sched_mode == mcps_pkg::MODE_FIFO) begin
      new_prio = arrival_counter;
    end else if (new_r && sched_mode == mcps_pkg::MODE_SJF) begin
      new_prio = trem_r;
    end else begin
      new_prio = preq_r;
    end
  end

  assign take_worst = (scan == '0) || (rd_prio > worst_prio);
  assign scan_last  = mcps_pkg::CPUN_W'(scan) == ncpu - mcps_pkg::CPUN_W'(1);

  // sequencer
  always_comb begin
    state_next      = state;
    qcount_next     = qcount;
    q_ins           = 1'b0;
    q_pop           = 1'b0;
    ins_proc        = proc_r;
    ins_prio        = new_prio;
    tbl_load        = 1'b0;
    tbl_clear       = 1'b0;
    scan_next       = scan;
    worst_next      = worst;
    worst_prio_next = worst_prio;
    wake_prio_next  = wake_prio;
    arrival_next    = arrival_counter;
    emit            = 1'b0;
    emit_kind       = mcps_pkg::KIND_DISPATCH;
    emit_cpu        = cpu_r;
    emit_proc       = '0;
    emit_idle       = 1'b0;
    case (state)
      mcps_pkg::S_IDLE: begin
        if (evt_valid) begin
          state_next = mcps_pkg::S_EXEC;
        end
      end
      mcps_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = mcps_pkg::S_IDLE;
          if (req_r == mcps_pkg::REQ_WAKE) begin
            if (qcount >= mcps_pkg::CNT_W'(mcps_pkg::QUEUE_DEPTH)) begin
              emit      = 1'b1;
              emit_kind = mcps_pkg::KIND_FULL;
              emit_cpu  = '0;
              emit_proc = proc_r;
            end else begin
              q_ins          = 1'b1;
              wake_prio_next = new_prio;
              if (new_r && sched_mode == mcps_pkg::MODE_FIFO) begin
                arrival_next = arrival_counter + mcps_pkg::PRIO_W'(1);
              end
              if (sched_mode == mcps_pkg::MODE_PRIO) begin
                scan_next  = '0;
                state_next = mcps_pkg::S_SCAN;
              end
            end
          end else if (!cpu_bad) begin
            case (req_r)
              mcps_pkg::REQ_POLL: begin
                if (!rd_valid && qcount != '0) begin
                  state_next = mcps_pkg::S_DISP;
                end
              end
              mcps_pkg::REQ_PREEMPT: begin
                q_ins      = rd_valid;
                ins_proc   = rd_proc;
                ins_prio   = rd_prio;
                state_next = mcps_pkg::S_DISP;
              end
              mcps_pkg::REQ_YIELD, mcps_pkg::REQ_TERM: begin
                state_next = mcps_pkg::S_DISP;
              end
              default: begin
                state_next = mcps_pkg::S_IDLE;
              end
            endcase
          end
          if (q_ins && qcount <= mcps_pkg::CNT_W'(mcps_pkg::QUEUE_DEPTH)) begin
            qcount_next = qcount + mcps_pkg::CNT_W'(1);
          end else begin
            q_ins = 1'b0;
          end
        end
      end
      mcps_pkg::S_SCAN: begin
        if (out_free) begin
          if (!rd_valid) begin
            state_next = mcps_pkg::S_IDLE;
          end else begin
            if (take_worst) begin
              worst_next      = scan;
              worst_prio_next = rd_prio;
            end
            if (scan_last) begin
              state_next = mcps_pkg::S_IDLE;
              if (wake_prio < worst_prio_next) begin
                emit      = 1'b1;
                emit_kind = mcps_pkg::KIND_PREEMPT;
                emit_cpu  = worst_next;
              end
            end else begin
              scan_next = scan + mcps_pkg::CPU_W'(1);
            end
          end
        end
      end
      mcps_pkg::S_DISP: begin
        if (out_free) begin
          state_next = mcps_pkg::S_IDLE;
          emit       = 1'b1;
          if (qcount != '0) begin
            tbl_load    = 1'b1;
            q_pop       = 1'b1;
            qcount_next = qcount - mcps_pkg::CNT_W'(1);
            emit_proc   = qproc[0];
          end else begin
            tbl_clear = 1'b1;
            emit_idle = 1'b1;
          end
        end
      end
      default: begin
        state_next = mcps_pkg::S_IDLE;
      end
    endcase
  end

  // insert position: a cell stays when it holds an equal or better priority
  always_comb begin
    for (int k = 0; k < mcps_pkg::QCELLS; k++) begin
      le[k] = (mcps_pkg::CNT_W'(k) < qcount) && (qprio[k] <= ins_prio);
    end
  end

  always_ff @(posedge clk) begin
    if (q_ins) begin
      if (!le[0]) begin
        qproc[0] <= ins_proc;
        qprio[0] <= ins_prio;
      end
      for (int k = 1; k < mcps_pkg::QCELLS; k++) begin
        if (!le[k]) begin
          if (le[k-1]) begin
            qproc[k] <= ins_proc;
            qprio[k] <= ins_prio;
          end else begin
            qproc[k] <= qproc[k-1];
            qprio[k] <= qprio[k-1];
          end
        end
      end
    end else if (q_pop) begin
      for (int k = 0; k < mcps_pkg::QCELLS - 1; k++) begin
        qproc[k] <= qproc[k+1];
        qprio[k] <= qprio[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcps_pkg::S_IDLE && evt_valid) begin
      req_r  <= mcps_pkg::req_t'(req_type);
      cpu_r  <= cpu_id;
      proc_r <= proc_id;
      new_r  <= is_new;
      preq_r <= priority_req;
      trem_r <= job_left;
    end
    if (tbl_load) begin
      run_proc[cpu_r] <= qproc[0];
      run_prio[cpu_r] <= qprio[0];
    end
    scan       <= scan_next;
    worst      <= worst_next;
    worst_prio <= worst_prio_next;
    wake_prio  <= wake_prio_next;
    if (emit) begin
      out_kind <= emit_kind;
      out_cpu  <= emit_cpu;
      out_proc <= emit_proc;
      out_idle <= emit_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mcps_pkg::S_IDLE;
      qcount          <= '0;
      run_valid       <= '0;
      arrival_counter <= '0;
      sched_mode      <= mcps_pkg::MODE_FIFO;
      ncpu_cfg        <= mcps_pkg::CCNT_W'(1);
      res_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      qcount          <= qcount_next;
      arrival_counter <= arrival_next;
      if (tbl_load) begin
        run_valid[cpu_r] <= 1'b1;
      end else if (tbl_clear) begin
        run_valid[cpu_r] <= 1'b0;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          mcps_pkg::CFG_SCHED_MODE: sched_mode <= cfg_data[mcps_pkg::MODE_W-1:0];
          mcps_pkg::CFG_NCPU:       ncpu_cfg   <= cfg_data[mcps_pkg::CCNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  `MCPS_ASSERT_NOW(a_qcount_idle, state == mcps_pkg::S_IDLE, qcount <= mcps_pkg::CNT_W'(mcps_pkg::QUEUE_DEPTH), "queue holds more than its depth between words")
  `MCPS_ASSERT_NEXT(a_busy_after_take, evt_valid && evt_ready, state == mcps_pkg::S_EXEC, "event word taken without starting work")
  `MCPS_ASSERT_NOW(a_scan_on_wake, state == mcps_pkg::S_SCAN, req_r == mcps_pkg::REQ_WAKE, "cpu table scan outside a wake")

endmodule

`default_nettype wire

>>> dv/tb_multi_cpu_priority_scheduler.sv
// self-checking testbench for the multi-cpu priority scheduler: event driver, result monitor, predictor
module tb_multi_cpu_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import mcps_pkg::*;

  localparam int IDLE_PCT    = 28;
  localparam int SETTLE      = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int BACKLOG_MAX = 32;
  localparam int MAX_REPORTS = 100;
  localparam int NPHASE      = 9;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [CPU_W-1:0]  cpu;
    logic [PROC_W-1:0] proc;
    logic              fresh;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] trem;
  } sched_evt_t;

  typedef struct packed {
    kind_t             kind;
    logic [CPU_W-1:0]  cpu;
    logic [PROC_W-1:0] proc;
    logic              idle;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst;
  logic evt_valid, evt_ready;
  logic [REQ_W-1:0]  req_type;
  logic [CPU_W-1:0]  cpu_id;
  logic [PROC_W-1:0] proc_id;
  logic              is_new;
  logic [PRIO_W-1:0] priority_req, job_left;
  logic res_valid, res_ready;
  logic [KIND_W-1:0] out_kind;
  logic [CPU_W-1:0]  out_cpu;
  logic [PROC_W-1:0] out_proc;
  logic              out_idle;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multi_cpu_priority_scheduler u_top (
    .clk(clk), .rst(rst),
    .evt_valid(evt_valid), .evt_ready(evt_ready),
    .req_type(req_type), .cpu_id(cpu_id), .proc_id(proc_id), .is_new(is_new),
    .priority_req(priority_req), .job_left(job_left),
    .res_valid(res_valid), .res_ready(res_ready),
    .out_kind(out_kind), .out_cpu(out_cpu), .out_proc(out_proc), .out_idle(out_idle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state as predicted
  logic [PROC_W-1:0] rq_proc [QCELLS];
  logic [PRIO_W-1:0] rq_prio [QCELLS];
  int                rq_cnt;
  logic [PROC_W-1:0] run_proc [MAX_CPUS];
  logic [PRIO_W-1:0] run_prio [MAX_CPUS];
  bit                run_busy [MAX_CPUS];
  logic [PRIO_W-1:0] arr_ctr;
  logic [MODE_W-1:0] cur_mode;
  logic [CCNT_W-1:0] cur_cnt;

  sched_res_t resp_due [$];
  sched_evt_t evt_backlog [$];
  sched_evt_t nxt;
  sched_res_t got;

  int  errors, pushed, taken, stall_cycles, hold_left;
  int  n_used, worst;
  bit  all_busy, fired, no_gaps, hold_req, evt_took, cfg_took;
  logic [PRIO_W-1:0] wake_prio;

  function automatic int cpus_used();
    if (cur_cnt == 0) return 1;
    if (cur_cnt > MAX_CPUS) return MAX_CPUS;
    return cur_cnt;
  endfunction

  // insert behind every entry of equal or better priority
  function automatic void rq_insert(input logic [PROC_W-1:0] p, input logic [PRIO_W-1:0] pr);
    int pos;
    pos = 0;
    if (rq_cnt > QUEUE_DEPTH) return;
    while (pos < rq_cnt && rq_prio[pos] <= pr) pos++;
    for (int i = rq_cnt; i > pos; i--) begin
      rq_proc[i] = rq_proc[i-1];
      rq_prio[i] = rq_prio[i-1];
    end
    rq_proc[pos] = p;
    rq_prio[pos] = pr;
    rq_cnt++;
  endfunction

  function automatic void give_cpu(input int c);
    sched_res_t r;
    r.kind = KIND_DISPATCH;
    r.cpu  = CPU_W'(c);
    if (rq_cnt > 0) begin
      run_proc[c] = rq_proc[0];
      run_prio[c] = rq_prio[0];
      run_busy[c] = 1'b1;
      for (int i = 1; i < rq_cnt; i++) begin
        rq_proc[i-1] = rq_proc[i];
        rq_prio[i-1] = rq_prio[i];
      end
      rq_cnt--;
      r.proc = run_proc[c];
      r.idle = 1'b0;
    end else begin
      run_busy[c] = 1'b0;
      r.proc = '0;
      r.idle = 1'b1;
    end
    resp_due.push_back(r);
  endfunction

  // event driver
  always @(negedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || evt_took) begin
      evt_took = 1'b0;
      if (evt_backlog.size() > 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = evt_backlog.pop_front();
        evt_valid      <= 1'b1;
        req_type       <= nxt.req;
        cpu_id         <= nxt.cpu;
        proc_id        <= nxt.proc;
        is_new         <= nxt.fresh;
        priority_req   <= nxt.prio;
        job_left       <= nxt.trem;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (!rst) begin
      fired = 1'b0;
      if (res_valid && res_ready) begin
        fired = 1'b1;
        if (resp_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result word with none pending, kind %0d cpu %0d proc %0d idle %0d",
                     $time, out_kind, out_cpu, out_proc, out_idle);
        end else begin
          got = resp_due.pop_front();
          if (out_kind !== got.kind) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_kind expected %0d actual %0d", $time, got.kind, out_kind);
          end
          if (out_cpu !== got.cpu) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_cpu expected %0d actual %0d", $time, got.cpu, out_cpu);
          end
          if (out_proc !== got.proc) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_proc expected %0d actual %0d", $time, got.proc, out_proc);
          end
          if (out_idle !== got.idle) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_idle expected %0d actual %0d", $time, got.idle, out_idle);
          end
        end
      end

      if (evt_valid && evt_ready) begin
        fired = 1'b1;
        evt_took = 1'b1;
        taken++;
        n_used = cpus_used();
        if (req_type == REQ_WAKE) begin
          if (rq_cnt >= QUEUE_DEPTH) begin
            got.kind = KIND_FULL;
            got.cpu  = '0;
            got.proc = proc_id;
            got.idle = 1'b0;
            resp_due.push_back(got);
          end else begin
            wake_prio = priority_req;
            if (is_new && cur_mode == MODE_FIFO) begin
              wake_prio = arr_ctr;
              arr_ctr = arr_ctr + 1'b1;
            end else if (is_new && cur_mode == MODE_SJF) begin
              wake_prio = job_left;
            end
            rq_insert(proc_id, wake_prio);
            if (cur_mode == MODE_PRIO) begin
              worst = 0;
              all_busy = 1'b1;
              for (int i = 0; i < n_used; i++) begin
                if (!run_busy[i]) all_busy = 1'b0;
                else if (all_busy && run_prio[i] > run_prio[worst]) worst = i;
              end
              if (all_busy && wake_prio < run_prio[worst]) begin
                got.kind = KIND_PREEMPT;
                got.cpu  = CPU_W'(worst);
                got.proc = '0;
                got.idle = 1'b0;
                resp_due.push_back(got);
              end
            end
          end
        end else if (req_type <= REQ_POLL && cpu_id < n_used) begin
          if (req_type == REQ_POLL) begin
            if (!run_busy[cpu_id] && rq_cnt > 0) give_cpu(cpu_id);
          end else begin
            if (req_type == REQ_PREEMPT && run_busy[cpu_id])
              rq_insert(run_proc[cpu_id], run_prio[cpu_id]);
            run_busy[cpu_id] = 1'b0;
            give_cpu(cpu_id);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        fired = 1'b1;
        cfg_took = 1'b1;
        case (cfg_index)
          CFG_SCHED_MODE: cur_mode = cfg_data[MODE_W-1:0];
          CFG_NCPU:       cur_cnt  = cfg_data[CCNT_W-1:0];
          default: ;
        endcase
      end

      if (fired) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_evt(input logic [REQ_W-1:0] rq, input logic [CPU_W-1:0] c,
                          input logic [PROC_W-1:0] p, input logic f,
                          input logic [PRIO_W-1:0] pr, input logic [PRIO_W-1:0] t);
    sched_evt_t e;
    e.req = rq;
    e.cpu = c;
    e.proc = p;
    e.fresh = f;
    e.prio = pr;
    e.trem = t;
    @(posedge clk);
    while (evt_backlog.size() >= BACKLOG_MAX) @(posedge clk);
    evt_backlog.push_back(e);
    pushed++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_took = 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // every sent word taken, every result word seen, then let the block settle
  task automatic drain_wait();
    do @(negedge clk); while (taken != pushed || resp_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode_count(input logic [MODE_W-1:0] m, input logic [CCNT_W-1:0] n);
    cfg_write(CFG_SCHED_MODE, {2'($urandom_range(0, 3)), m});
    cfg_write(CFG_NCPU, n);
  endtask

  // fill and drain bursts, picked at random every 40 items, with random content
  task automatic rand_items(input int n);
    int fill_burst, roll, n_cpu;
    logic [REQ_W-1:0]  rq;
    logic [CPU_W-1:0]  c;
    logic [PRIO_W-1:0] pr, t;
    fill_burst = 1;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) fill_burst = $urandom_range(0, 1);
      n_cpu = cpus_used();
      roll = $urandom_range(0, 99);
      if (fill_burst) begin
        if (roll < 78) rq = REQ_WAKE;
        else if (roll < 84) rq = REQ_PREEMPT;
        else if (roll < 89) rq = REQ_YIELD;
        else if (roll < 93) rq = REQ_TERM;
        else if (roll < 98) rq = REQ_POLL;
        else rq = REQ_W'($urandom_range(REQ_POLL + 1, 2**REQ_W - 1));
      end else begin
        if (roll < 20) rq = REQ_WAKE;
        else if (roll < 35) rq = REQ_PREEMPT;
        else if (roll < 55) rq = REQ_YIELD;
        else if (roll < 75) rq = REQ_TERM;
        else if (roll < 97) rq = REQ_POLL;
        else rq = REQ_W'($urandom_range(REQ_POLL + 1, 2**REQ_W - 1));
      end
      c  = ($urandom_range(0, 9) == 0) ? CPU_W'($urandom) : CPU_W'($urandom_range(0, n_cpu - 1));
      pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom);
      t  = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom);
      send_evt(rq, c, PROC_W'($urandom), 1'($urandom), pr, t);
    end
  endtask

  int ph_mode [NPHASE] = '{1, 1, 2, 0, 3, 1, 2, 1, 0};
  int ph_cnt  [NPHASE] = '{8, 2, 4, 3, 1, 0, 15, 9, 8};

  initial begin
    rst = 1'b1;
    evt_valid = 1'b0;
    req_type = '0;
    cpu_id = '0;
    proc_id = '0;
    is_new = 1'b0;
    priority_req = '0;
    job_left = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rq_cnt = 0;
    arr_ctr = '0;
    cur_mode = MODE_FIFO;
    cur_cnt = 1;
    for (int i = 0; i < MAX_CPUS; i++) begin
      run_busy[i] = 1'b0;
      run_proc[i] = '0;
      run_prio[i] = '0;
    end
    for (int i = 0; i < QCELLS; i++) begin
      rq_proc[i] = '0;
      rq_prio[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: fifo order, one cpu
    send_evt(REQ_POLL, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_YIELD, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'hff, 1'b1, 16'hffff, 16'hffff);
    send_evt(REQ_WAKE, 7, 8'h00, 1'b1, 16'h0000, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'h55, 1'b0, 16'hffff, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'haa, 1'b0, 16'h0000, 16'hffff);
    send_evt(REQ_WAKE, 0, 8'h3c, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_POLL, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_POLL, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_PREEMPT, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_TERM, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_YIELD, 7, 8'hff, 1'b1, 16'hffff, 16'hffff);
    for (int k = REQ_POLL + 1; k < 2**REQ_W; k++)
      send_evt(REQ_W'(k), 0, 8'h12, 1'b0, 16'h0001, 16'h0001);
    send_evt(REQ_PREEMPT, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    drain_wait();

    // static priority on two cpus: a dispatch on poll, then wakes that preempt no cpu
    set_mode_count(MODE_PRIO, 2);
    send_evt(REQ_POLL, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_POLL, 1, 8'h00, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'h21, 1'b0, 16'h0000, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'h22, 1'b0, 16'hffff, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'h23, 1'b1, 16'h0002, 16'hffff);
    drain_wait();

    set_mode_count(MODE_SJF, 1);
    send_evt(REQ_WAKE, 0, 8'h31, 1'b1, 16'hffff, 16'h0000);
    send_evt(REQ_WAKE, 0, 8'h32, 1'b1, 16'h0000, 16'hffff);
    send_evt(REQ_WAKE, 0, 8'h33, 1'b0, 16'h0005, 16'h0000);
    send_evt(REQ_TERM, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    drain_wait();

    // unknown mode and every cpu in use
    set_mode_count(MODE_W'(2**MODE_W - 1), MAX_CPUS);
    send_evt(REQ_WAKE, 0, 8'h41, 1'b1, 16'h0000, 16'h0000);
    drain_wait();
    for (int k = CFG_NCPU + 1; k < 2**CFG_IDX_W; k++)
      cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));

    for (int ph = 0; ph < NPHASE; ph++) begin
      drain_wait();
      set_mode_count(MODE_W'(ph_mode[ph]), CCNT_W'(ph_cnt[ph]));
      no_gaps = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      rand_items(110);
    end

    // fifo mode, one cpu, no gaps
    drain_wait();
    no_gaps = 1'b1;
    set_mode_count(MODE_FIFO, 1);
    for (int k = 0; k < 8; k++)
      send_evt(REQ_WAKE, 0, PROC_W'($urandom), 1'b1, PRIO_W'($urandom), PRIO_W'($urandom));
    for (int k = 0; k < 10; k++)
      send_evt(REQ_TERM, 0, 8'h00, 1'b0, 16'h0000, 16'h0000);
    no_gaps = 1'b0;

    drain_wait();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mcps_pkg.sv
hw/rtl/multi_cpu_priority_scheduler.sv
dv/tb_multi_cpu_priority_scheduler.sv
